// ===== sv/one_shot_timer_pool_assert.svh =====
// Assertion macros for the one-shot timer pool.
`ifndef ONE_SHOT_TIMER_POOL_ASSERT_SVH
`define ONE_SHOT_TIMER_POOL_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define OSTP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
// Condition must never be true outside reset.
`define OSTP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define OSTP_ASSERT(lbl, clk, rstn, prop, msg)
`define OSTP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/ostp_pkg.sv =====
// Shared codes and controller/datapath handshake types for the timer pool.
`default_nettype none
package ostp_pkg;

  // Request kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_INSERT   = 2'd1;
  localparam logic [1:0] KIND_DELETE   = 2'd2;
  localparam logic [1:0] KIND_FREE_ALL = 2'd3;

  // Reply kinds
  localparam logic [1:0] REPLY_GRANTED = 2'd0;
  localparam logic [1:0] REPLY_FULL    = 2'd1;
  localparam logic [1:0] REPLY_FIRED   = 2'd2;

  // At most four fired replies per tick; further due slots are freed silently.
  localparam int unsigned FIRE_CNT_W   = 2;
  localparam logic [FIRE_CNT_W-1:0] FIRE_CNT_LAST = 2'd3;

  typedef struct packed {
    logic capture;    // latch the accepted request
    logic exec_tick;  // load time, snapshot due slots, free them
    logic exec_ins;   // insert into lowest free slot, reply
    logic exec_del;   // free the target slot
    logic exec_clr;   // free every slot
    logic fire;       // emit the lowest pending fired slot
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;       // kind of latched request
    logic       due_any;    // fired slots still pending
    logic       fire_last;  // next fired reply closes the tick
    logic       can_load;   // result register can take a reply
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/ostp_req_if.sv =====
// Request channel of the timer pool.
`default_nettype none
interface ostp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [47:0] now_cycles;
  logic [31:0] duration;
  logic [15:0] user_param;
  logic [1:0]  handler_id;
  logic [1:0]  target_slot;

  modport source (
    output valid, kind, now_cycles, duration, user_param, handler_id, target_slot,
    input  ready
  );
  modport sink (
    input  valid, kind, now_cycles, duration, user_param, handler_id, target_slot,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/ostp_rsp_if.sv =====
// Reply channel of the timer pool.
`default_nettype none
interface ostp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [1:0]  slot;
  logic [15:0] fired_param;
  logic [1:0]  fired_handler;
  logic        last;

  modport source (
    output valid, reply_kind, slot, fired_param, fired_handler, last,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, slot, fired_param, fired_handler, last,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/one_shot_timer_pool.sv =====
// Top level of the one-shot timer pool: controller plus datapath.
//
//   channel  dir  payload                                              handshake
//   req_i    in   kind, now_cycles, duration, user_param, handler_id,  valid/ready
//                 target_slot
//   rsp_o    out  reply_kind, slot, fired_param, fired_handler, last   valid/ready
//
// One request at a time. A request is accepted in idle, then executes the
// next cycle: delete and free-all finish in the execute state, insert also
// waits on the result register, and a tick goes on to the fire state,
// which emits the fired replies (at most four replies; further due slots are
// freed without a reply).
// The single result register sets the pace of replies; while it is full and
// not taken, the insert or fire step holds.
// Reset is asynchronous and clears time, slot valid bits and control; slot
// contents are not cleared and are only read for active or due slots.
`default_nettype none
module one_shot_timer_pool #(
  parameter int unsigned SLOTS     = 4,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ostp_req_if.sink   req_i,
  ostp_rsp_if.source rsp_o
);

  ostp_pkg::cmd_t cmd;
  ostp_pkg::sts_t sts;
  logic           in_ready;

  assign req_i.ready = in_ready;

  // sequencing: accept, execute, emit fired replies
  ostp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot store, time register, due snapshot and result register
  ostp_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (req_i.kind),
    .now_cycles_i  (req_i.now_cycles),
    .duration_i    (req_i.duration),
    .user_param_i  (req_i.user_param),
    .handler_id_i  (req_i.handler_id),
    .target_slot_i (req_i.target_slot),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_o         (rsp_o)
  );

endmodule
`default_nettype wire

// ===== sv/ostp_ctrl.sv =====
// Controller state machine of the timer pool.
`default_nettype none
module ostp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  ostp_pkg::sts_t     sts_i,
  output ostp_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIRE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.kind)
          ostp_pkg::KIND_TICK: begin
            cmd_o.exec_tick = 1'b1;
            state_d         = ST_FIRE;
          end
          ostp_pkg::KIND_INSERT: begin
            cmd_o.exec_ins = 1'b1;
            if (sts_i.can_load) begin
              state_d = ST_IDLE;
            end
          end
          ostp_pkg::KIND_DELETE: begin
            cmd_o.exec_del = 1'b1;
            state_d        = ST_IDLE;
          end
          ostp_pkg::KIND_FREE_ALL: begin
            cmd_o.exec_clr = 1'b1;
            state_d        = ST_IDLE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FIRE: begin
        if (!sts_i.due_any) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.fire = 1'b1;
          if (sts_i.can_load && sts_i.fire_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ostp_dp.sv =====
// Datapath of the timer pool: slot store, time, due snapshot, result register.
`default_nettype none
`include "one_shot_timer_pool_assert.svh"
module ostp_dp #(
  parameter int unsigned SLOTS     = 4,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  kind_i,
  input  wire logic [47:0] now_cycles_i,
  input  wire logic [31:0] duration_i,
  input  wire logic [15:0] user_param_i,
  input  wire logic [1:0]  handler_id_i,
  input  wire logic [1:0]  target_slot_i,
  input  ostp_pkg::cmd_t   cmd_i,
  output ostp_pkg::sts_t   sts_o,
  ostp_rsp_if.source       rsp_o
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam int unsigned FIRE_CNT_W_L = ostp_pkg::FIRE_CNT_W;

  // latched request
  logic [1:0]  kind_q;
  logic [47:0] now_q;
  logic [31:0] dur_q;
  logic [15:0] param_q;
  logic [1:0]  hnd_q;
  logic [1:0]  tgt_q;

  // pool state
  logic [TIME_BITS-1:0] cur_q;
  logic [SLOTS-1:0]     active_q;
  logic [SLOTS-1:0]     due_q;
  logic [FIRE_CNT_W_L-1:0] cnt_q;
  logic [TIME_BITS-1:0] dl_q    [SLOTS];
  logic [15:0]          prm_q   [SLOTS];
  logic [1:0]           hdl_q   [SLOTS];

  // result register
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [1:0]  out_slot_q;
  logic [15:0] out_param_q;
  logic [1:0]  out_hnd_q;
  logic        out_last_q;

  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic [SLOTS-1:0]     due_vec;
  logic [SLOT_W-1:0]    free_idx;
  logic                 full;
  logic [SLOT_W-1:0]    fire_idx;
  logic [SLOTS-1:0]     low_oh;
  logic [SLOTS-1:0]     rest;
  logic                 fire_last;
  logic                 can_load;
  logic                 load_out;
  logic                 ins_go;
  logic                 fire_go;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] deadline_new;
  logic [4:0]           free_ext;
  logic [4:0]           fire_ext;

  assign now_ext = {16'b0, now_q};
  assign now_t   = now_ext[TIME_BITS-1:0];

  // one compare per slot against the new time
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      due_vec[i] = active_q[i] && (now_t >= dl_q[i]);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) free_idx = SLOT_W'(i);
    end
  end
  assign full = &active_q;

  // lowest pending fired slot
  always_comb begin
    fire_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (due_q[i]) fire_idx = SLOT_W'(i);
    end
  end
  assign low_oh    = due_q & (~due_q + SLOTS'(1));
  assign rest      = due_q & ~low_oh;
  assign fire_last = (rest == '0) || (cnt_q == ostp_pkg::FIRE_CNT_LAST);

  // saturating deadline
  assign sum          = SUM_W'(cur_q) + SUM_W'(dur_q);
  assign deadline_new = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  assign free_ext = 5'(free_idx);
  assign fire_ext = 5'(fire_idx);

  assign can_load = !out_valid_q || rsp_o.ready;
  assign load_out = (cmd_i.exec_ins || cmd_i.fire) && can_load;
  assign ins_go   = cmd_i.exec_ins && can_load && !full;
  assign fire_go  = cmd_i.fire && can_load;

  assign sts_o.kind      = kind_q;
  assign sts_o.due_any   = |due_q;
  assign sts_o.fire_last = fire_last;
  assign sts_o.can_load  = can_load;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      now_q   <= now_cycles_i;
      dur_q   <= duration_i;
      param_q <= user_param_i;
      hnd_q   <= handler_id_i;
      tgt_q   <= target_slot_i;
    end
    if (ins_go) begin
      dl_q[free_idx]  <= deadline_new;
      prm_q[free_idx] <= param_q;
      hdl_q[free_idx] <= hnd_q;
    end
    if (load_out) begin
      if (cmd_i.fire) begin
        out_kind_q  <= ostp_pkg::REPLY_FIRED;
        out_slot_q  <= fire_ext[1:0];
        out_param_q <= prm_q[fire_idx];
        out_hnd_q   <= hdl_q[fire_idx];
        out_last_q  <= fire_last;
      end else begin
        out_kind_q  <= full ? ostp_pkg::REPLY_FULL : ostp_pkg::REPLY_GRANTED;
        out_slot_q  <= full ? 2'd0 : free_ext[1:0];
        out_param_q <= '0;
        out_hnd_q   <= '0;
        out_last_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      active_q    <= '0;
      due_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec_tick) begin
        cur_q    <= now_t;
        due_q    <= due_vec;
        active_q <= active_q & ~due_vec;
        cnt_q    <= '0;
      end
      if (ins_go) begin
        active_q[free_idx] <= 1'b1;
      end
      if (cmd_i.exec_del) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (32'(tgt_q) == i) active_q[i] <= 1'b0;
        end
      end
      if (cmd_i.exec_clr) begin
        active_q <= '0;
      end
      if (fire_go) begin
        due_q <= fire_last ? '0 : rest;
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.reply_kind    = out_kind_q;
  assign rsp_o.slot          = out_slot_q;
  assign rsp_o.fired_param   = out_param_q;
  assign rsp_o.fired_handler = out_hnd_q;
  assign rsp_o.last          = out_last_q;

  `OSTP_ASSERT_NEVER(a_due_freed, clk_i, rst_ni, |(due_q & active_q), "due slot still active")
  `OSTP_ASSERT(a_last_drains, clk_i, rst_ni, (fire_go && fire_last) |=> due_q == '0, "fires left")
  `OSTP_ASSERT(a_grant_active, clk_i, rst_ni, ins_go |=> active_q[$past(free_idx)], "grant lost")

endmodule
`default_nettype wire

// ===== tb/sv/ostp_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the timer pool: mirrors the slot table and checks every reply.
module ostp_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  ostp_req_if  req_i,
  ostp_rsp_if  rsp_i,
  output int   mismatches_o,
  output int   waiting_o
);
  import ostp_pkg::*;

  localparam int unsigned SLOTS = 4;
  localparam logic [47:0] TIME_TOP = '1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  slot;
    logic [15:0] param;
    logic [1:0]  handler;
    logic        last;
  } reply_t;

  // mirror of the pool
  logic [47:0] now_q;
  logic [SLOTS-1:0] busy_q;
  logic [47:0] deadline_q [SLOTS];
  logic [15:0] param_q [SLOTS];
  logic [1:0]  handler_q [SLOTS];

  reply_t replies_q [$];
  int errors;

  function automatic void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  // Update the mirror for one accepted request and queue the replies it causes.
  task automatic apply_request();
    logic [48:0] sum;
    int s;
    int free_slot;
    int fired;
    fired = 0;
    case (req_i.kind)
      KIND_TICK: begin
        now_q = req_i.now_cycles;
        for (s = 0; s < SLOTS; s++) begin
          if (busy_q[s] && now_q >= deadline_q[s]) begin
            busy_q[s] = 1'b0;
            replies_q.push_back('{REPLY_FIRED, 2'(s), param_q[s], handler_q[s], 1'b0});
            fired++;
          end
        end
        if (fired != 0) replies_q[$].last = 1'b1;
      end
      KIND_INSERT: begin
        free_slot = SLOTS;
        for (s = SLOTS - 1; s >= 0; s--) if (!busy_q[s]) free_slot = s;
        if (free_slot < SLOTS) begin
          sum = {1'b0, now_q} + {17'b0, req_i.duration};
          deadline_q[free_slot] = sum[48] ? TIME_TOP : sum[47:0];
          param_q[free_slot]    = req_i.user_param;
          handler_q[free_slot]  = req_i.handler_id;
          busy_q[free_slot]     = 1'b1;
          replies_q.push_back('{REPLY_GRANTED, 2'(free_slot), 16'h0, 2'd0, 1'b1});
        end else begin
          replies_q.push_back('{REPLY_FULL, 2'd0, 16'h0, 2'd0, 1'b1});
        end
      end
      KIND_DELETE: busy_q[req_i.target_slot] = 1'b0;
      default:     busy_q = '0;
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    reply_t got;
    got = '{rsp_i.reply_kind, rsp_i.slot, rsp_i.fired_param, rsp_i.fired_handler, rsp_i.last};
    if (replies_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected reply, expected none, actual %0h", $time, got);
    end else begin
      want = replies_q.pop_front();
      if (got.kind !== want.kind)       note_mismatch("reply_kind", want.kind, got.kind);
      if (got.slot !== want.slot)       note_mismatch("slot", want.slot, got.slot);
      if (got.param !== want.param)     note_mismatch("fired_param", want.param, got.param);
      if (got.handler !== want.handler) note_mismatch("fired_handler", want.handler, got.handler);
      if (got.last !== want.last)       note_mismatch("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  = '0;
      busy_q = '0;
      replies_q.delete();
      errors = 0;
      mismatches_o <= 0;
      waiting_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) check_reply();
      if (req_i.valid && req_i.ready) apply_request();
      mismatches_o <= errors;
      waiting_o    <= replies_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the timer pool: clock, reset, request stimulus, reply pacing, verdict.
module tb;
  import ostp_pkg::*;

  // No progress on either channel for this long means the block is stuck.
  localparam int unsigned STALL_LIMIT = 2000;
  // Longest request is a tick with four fired replies; keep margin.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_PER_PHASE = 52;
  localparam logic [47:0] TIME_MAX = '1;
  localparam logic [31:0] DUR_MAX  = '1;

  logic clk;
  logic rst_n;

  ostp_req_if req_bus ();
  ostp_rsp_if rsp_bus ();

  int mismatches;
  int waiting;

  // Percent of cycles in which the request side holds off / the reply side stalls.
  int unsigned src_idle_pct = 15;
  int unsigned rcv_idle_pct = 71;
  int unsigned quiet_cycles;

  // Running time base for random ticks; mostly creeps forward, sometimes jumps.
  logic [47:0] sim_now;

  one_shot_timer_pool i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  ostp_scoreboard i_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .mismatches_o (mismatches),
    .waiting_o    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reply side: random stalls, re-rolled every cycle.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Present one request and hold it until it is taken. valid is only dropped
  // when a gap is actually inserted, so back-to-back requests keep it high.
  task automatic send_req(input logic [1:0] kind, input logic [47:0] now,
                          input logic [31:0] dur, input logic [15:0] prm,
                          input logic [1:0] hnd, input logic [1:0] tgt);
    if ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_bus.valid       <= 1'b1;
    req_bus.kind        <= kind;
    req_bus.now_cycles  <= now;
    req_bus.duration    <= dur;
    req_bus.user_param  <= prm;
    req_bus.handler_id  <= hnd;
    req_bus.target_slot <= tgt;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Stop sending and wait until every outstanding reply has been taken.
  // Sampling waits on the clock first, so the last request is already counted.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Walks the corner cases: deadline equal to now, full pool, delete of a
  // busy and of a free slot, four fires in one tick, saturated deadline,
  // a tick that moves time backwards, free-all.
  task automatic run_directed();
    send_req(KIND_TICK,     48'd0,    32'd0,   16'h0000, 2'd0, 2'd0); // nothing due
    send_req(KIND_INSERT,   48'd0,    32'd0,   16'hFFFF, 2'd3, 2'd0); // slot 0
    send_req(KIND_TICK,     48'd0,    32'd0,   16'h0000, 2'd0, 2'd0); // due exactly now
    send_req(KIND_INSERT,   48'd0,    DUR_MAX, 16'h0000, 2'd0, 2'd0); // slot 0
    send_req(KIND_INSERT,   48'd0,    32'd5,   16'h1234, 2'd1, 2'd0); // slot 1
    send_req(KIND_INSERT,   48'd0,    32'd0,   16'hA5A5, 2'd2, 2'd0); // slot 2
    send_req(KIND_INSERT,   48'd0,    32'd100, 16'h5A5A, 2'd3, 2'd0); // slot 3
    send_req(KIND_INSERT,   48'd0,    32'd9,   16'hBEEF, 2'd2, 2'd0); // refused, full
    send_req(KIND_DELETE,   48'd0,    32'd0,   16'h0000, 2'd0, 2'd1); // busy slot
    send_req(KIND_DELETE,   48'd0,    32'd0,   16'h0000, 2'd0, 2'd1); // already free
    send_req(KIND_INSERT,   48'd0,    32'd7,   16'h0F0F, 2'd1, 2'd0); // slot 1 again
    send_req(KIND_TICK,     48'd6,    32'd0,   16'h0000, 2'd0, 2'd0); // only slot 2
    send_req(KIND_INSERT,   48'd0,    32'd1,   16'hF0F0, 2'd0, 2'd0); // slot 2
    send_req(KIND_TICK,     TIME_MAX, 32'd0,   16'h0000, 2'd0, 2'd0); // four fires
    send_req(KIND_INSERT,   48'd0,    DUR_MAX, 16'h7777, 2'd1, 2'd0); // saturates
    send_req(KIND_INSERT,   48'd0,    32'd0,   16'h8888, 2'd2, 2'd0); // slot 1
    send_req(KIND_TICK,     48'd0,    32'd0,   16'h0000, 2'd0, 2'd0); // time goes back
    send_req(KIND_TICK,     TIME_MAX, 32'd0,   16'h0000, 2'd0, 2'd0); // both fire
    send_req(KIND_INSERT,   48'd0,    32'd3,   16'h1111, 2'd3, 2'd0);
    send_req(KIND_INSERT,   48'd0,    32'd4,   16'h2222, 2'd0, 2'd0);
    send_req(KIND_FREE_ALL, 48'd0,    32'd0,   16'h0000, 2'd0, 2'd0);
    send_req(KIND_TICK,     TIME_MAX, 32'd0,   16'h0000, 2'd0, 2'd0); // nothing left
    send_req(KIND_DELETE,   48'd0,    32'd0,   16'h0000, 2'd0, 2'd3);
    send_req(KIND_DELETE,   48'd0,    32'd0,   16'h0000, 2'd0, 2'd0);
    send_req(KIND_TICK,     48'd0,    32'd0,   16'h0000, 2'd0, 2'd0);
  endtask

  // Random request. Inserts dominate so the pool fills up; short durations
  // against a slowly advancing clock make ticks fire often, with rare jumps
  // to random, near-top and near-zero times and rare huge durations.
  task automatic random_req();
    logic [1:0]  kind;
    logic [31:0] dur;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      kind = KIND_TICK;
    else if (pick < 80) kind = KIND_INSERT;
    else if (pick < 95) kind = KIND_DELETE;
    else                kind = KIND_FREE_ALL;
    pick = $urandom_range(99);
    if (pick < 85)      sim_now = sim_now + 48'($urandom_range(60));
    else if (pick < 92) sim_now = 48'({$urandom(), $urandom()});
    else if (pick < 96) sim_now = TIME_MAX - 48'($urandom_range(200));
    else                sim_now = 48'($urandom_range(200));
    pick = $urandom_range(99);
    if (pick < 88)      dur = 32'($urandom_range(150));
    else if (pick < 94) dur = DUR_MAX - 32'($urandom_range(3));
    else                dur = $urandom();
    send_req(kind, sim_now, dur, 16'($urandom()), 2'($urandom()), 2'($urandom()));
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    sim_now = '0;
    req_bus.valid       <= 1'b0;
    req_bus.kind        <= KIND_TICK;
    req_bus.now_cycles  <= '0;
    req_bus.duration    <= '0;
    req_bus.user_param  <= '0;
    req_bus.handler_id  <= '0;
    req_bus.target_slot <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    // Phase 0: sender mostly busy, receiver stalls a lot.
    // Phase 1: the other way round. Phase 2: full rate both sides.
    // Each phase ends with the sender holding off until all replies are in.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 15; rcv_idle_pct = 71; end
        1: begin src_idle_pct = 71; rcv_idle_pct = 15; end
        default: begin src_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      repeat (RANDOM_PER_PHASE) random_req();
      wait_drained();
    end

    // Let any stray reply surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
